// ===== design/v3alu_pkg.sv =====
// shared types, constants and helpers for the vec3 homogeneous alu
package v3alu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int NUM_LANES  = 4;
    localparam int NUM_MULS   = 2 * NUM_LANES;
    localparam int IN_DATA_W  = 9 * DATA_W;
    localparam int OUT_DATA_W = 5 * DATA_W;
    localparam int OP_W       = 4;
    localparam int STATUS_W   = 2;
    localparam int PROD_W     = 2 * (DATA_W + 1);
    localparam int WIDE_W     = PROD_W + 1;
    localparam int DVD_W      = DATA_W + FRAC_BITS;
    localparam int SQ_W       = 2 * DATA_W + FRAC_BITS;
    localparam int ROOT_W     = (SQ_W + 1) / 2;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int DIVS_W     = (ROOT_W > DATA_W) ? ROOT_W : DATA_W;
    localparam int CNT_W      = $clog2(DVD_W + 1);
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    localparam logic signed [DATA_W:0] ONE_Q =
        {{(DATA_W - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [WIDE_W-1:0] SAT_MAX =
        {{(WIDE_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAT_MIN =
        {{(WIDE_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_SCALE = 4'd2,
        OP_DIV   = 4'd3,
        OP_LERP  = 4'd4,
        OP_DOT   = 4'd5,
        OP_CROSS = 4'd6,
        OP_LEN   = 4'd7,
        OP_NORM  = 4'd8,
        OP_NOP   = 4'd15
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK  = 2'd0,
        STAT_DZ  = 2'd1,
        STAT_OVF = 2'd2
    } t_status;

    typedef struct packed {
        t_op                                 op;
        logic [NUM_LANES-1:0][DATA_W-1:0]    a;
        logic [NUM_LANES-1:0][DATA_W-1:0]    b;
        logic [DATA_W-1:0]                   s;
    } t_item;

    typedef struct packed {
        logic              ovf;
        logic [DATA_W-1:0] val;
    } t_sat;

    function automatic t_sat sat_val(input logic signed [WIDE_W-1:0] v);
        t_sat r;
        r.ovf = 1'b0;
        if (v > SAT_MAX) begin
            r.ovf = 1'b1;
            r.val = SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            r.ovf = 1'b1;
            r.val = SAT_MIN[DATA_W-1:0];
        end else begin
            r.val = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // magnitude of a signed word, fits unsigned in the same width
    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
        logic [DATA_W:0] e;
        e = {v[DATA_W-1], v};
        if (v[DATA_W-1]) begin
            e = ~e + 1'b1;
        end
        return e[DATA_W-1:0];
    endfunction

endpackage

// ===== design/v3alu_front.sv =====
// front end: accepts beats, classifies the opcode and queues items
module v3alu_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [v3alu_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic [v3alu_pkg::OP_W-1:0]     i_s_tuser,
    output v3alu_pkg::t_item               o_item,
    output logic                           o_item_valid,
    input  logic                           i_pop
);

    v3alu_pkg::t_item r_q [v3alu_pkg::Q_DEPTH];
    logic [v3alu_pkg::Q_AW-1:0] r_wr, r_rd;
    logic [v3alu_pkg::Q_AW:0]   r_count;
    v3alu_pkg::t_item n_item;
    logic push, pop;

    always_comb begin
        n_item.op = v3alu_pkg::OP_NOP;
        if (i_s_tuser inside {[v3alu_pkg::OP_ADD : v3alu_pkg::OP_NORM]}) begin
            n_item.op = v3alu_pkg::t_op'(i_s_tuser);
        end
        for (int k = 0; k < v3alu_pkg::NUM_LANES; k++) begin
            n_item.a[k] = i_s_tdata[k*v3alu_pkg::DATA_W +: v3alu_pkg::DATA_W];
            n_item.b[k] = i_s_tdata[(v3alu_pkg::NUM_LANES+k)*v3alu_pkg::DATA_W
                                    +: v3alu_pkg::DATA_W];
        end
        n_item.s = i_s_tdata[2*v3alu_pkg::NUM_LANES*v3alu_pkg::DATA_W
                             +: v3alu_pkg::DATA_W];
    end

    assign o_s_tready   = (r_count != (v3alu_pkg::Q_AW+1)'(v3alu_pkg::Q_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_q[r_rd];
    assign push         = i_s_tvalid && o_s_tready;
    assign pop          = i_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + v3alu_pkg::Q_AW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + v3alu_pkg::Q_AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (v3alu_pkg::Q_AW+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (v3alu_pkg::Q_AW+1)'(1);
            end
        end
    end

endmodule

// ===== design/v3alu_sqrt.sv =====
// bit-serial integer square root, one root bit per step
module v3alu_sqrt (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic                         i_step,
    input  logic [v3alu_pkg::RAD_W-1:0]  i_rad,
    output logic [v3alu_pkg::ROOT_W-1:0] o_root
);

    logic [v3alu_pkg::RAD_W-1:0]  r_rad;
    logic [v3alu_pkg::ROOT_W+1:0] r_rem;
    logic [v3alu_pkg::ROOT_W-1:0] r_root;
    logic [v3alu_pkg::ROOT_W+1:0] rem_sh, trial;

    assign rem_sh = {r_rem[v3alu_pkg::ROOT_W-1:0], r_rad[v3alu_pkg::RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_step) begin
            r_rad <= {r_rad[v3alu_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[v3alu_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[v3alu_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== design/v3alu_div_lane.sv =====
// restoring unsigned divider lane, one quotient bit per step
module v3alu_div_lane (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic                         i_step,
    input  logic [v3alu_pkg::DVD_W-1:0]  i_dividend,
    input  logic [v3alu_pkg::DIVS_W-1:0] i_divisor,
    output logic [v3alu_pkg::DVD_W-1:0]  o_quot
);

    logic [v3alu_pkg::DVD_W-1:0]  r_q;
    logic [v3alu_pkg::DIVS_W-1:0] r_div;
    logic [v3alu_pkg::DIVS_W:0]   r_rem;
    logic [v3alu_pkg::DIVS_W:0]   sh, dv;

    assign sh     = {r_rem[v3alu_pkg::DIVS_W-1:0], r_q[v3alu_pkg::DVD_W-1]};
    assign dv     = {1'b0, r_div};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q   <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (i_step) begin
            if (sh >= dv) begin
                r_rem <= sh - dv;
                r_q   <= {r_q[v3alu_pkg::DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= sh;
                r_q   <= {r_q[v3alu_pkg::DVD_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== design/v3alu_back.sv =====
// back end: sequencer, multipliers, sqrt and divide units, output register
module v3alu_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  v3alu_pkg::t_item                i_item,
    input  logic                            i_item_valid,
    output logic                            o_pop,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [v3alu_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [v3alu_pkg::STATUS_W-1:0]  o_m_tuser
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_SUM  = 6'b000100,
        ST_SQRT = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    localparam int DW = v3alu_pkg::DATA_W;
    localparam int WW = v3alu_pkg::WIDE_W;
    localparam int NL = v3alu_pkg::NUM_LANES;

    t_state r_state, n_state;
    logic [v3alu_pkg::CNT_W-1:0] r_cnt, n_cnt;
    v3alu_pkg::t_item r_item;
    logic [NL-1:0] r_neg, n_neg;

    logic signed [v3alu_pkg::PROD_W-1:0] r_prod [v3alu_pkg::NUM_MULS];
    logic signed [DW:0] mop_a [v3alu_pkg::NUM_MULS];
    logic signed [DW:0] mop_b [v3alu_pkg::NUM_MULS];
    logic signed [DW:0] a33 [NL];
    logic signed [DW:0] b33 [NL];
    logic signed [DW:0] s33, t33, omt33;

    logic [63:0] sum_sq;
    logic sq_load, sq_step;
    logic [v3alu_pkg::ROOT_W-1:0] root;
    logic dv_load, dv_step;
    logic [v3alu_pkg::DIVS_W-1:0] divisor;
    logic [v3alu_pkg::DVD_W-1:0]  dividend [NL];
    logic [v3alu_pkg::DVD_W-1:0]  quot [NL];

    logic signed [WW-1:0] lane_v [NL];
    logic signed [WW-1:0] scal_v;
    v3alu_pkg::t_sat lane_s [NL];
    v3alu_pkg::t_sat scal_s;
    logic dz, any_ovf, out_free;

    logic r_m_valid;
    logic [v3alu_pkg::OUT_DATA_W-1:0] r_m_data;
    logic [v3alu_pkg::STATUS_W-1:0]   r_m_user;

    // multiplier operand select
    always_comb begin
        s33 = {r_item.s[DW-1], r_item.s};
        if (r_item.s[DW-1]) begin
            t33 = '0;
        end else if (s33 > v3alu_pkg::ONE_Q) begin
            t33 = v3alu_pkg::ONE_Q;
        end else begin
            t33 = s33;
        end
        omt33 = v3alu_pkg::ONE_Q - t33;
        for (int k = 0; k < NL; k++) begin
            a33[k] = {r_item.a[k][DW-1], r_item.a[k]};
            b33[k] = {r_item.b[k][DW-1], r_item.b[k]};
        end
        for (int m = 0; m < v3alu_pkg::NUM_MULS; m++) begin
            mop_a[m] = '0;
            mop_b[m] = '0;
        end
        case (r_item.op)
            v3alu_pkg::OP_SCALE: begin
                for (int k = 0; k < NL; k++) begin
                    mop_a[2*k] = a33[k];
                    mop_b[2*k] = s33;
                end
            end
            v3alu_pkg::OP_LERP: begin
                for (int k = 0; k < NL; k++) begin
                    mop_a[2*k]   = a33[k];
                    mop_b[2*k]   = omt33;
                    mop_a[2*k+1] = b33[k];
                    mop_b[2*k+1] = t33;
                end
            end
            v3alu_pkg::OP_DOT: begin
                for (int k = 0; k < 3; k++) begin
                    mop_a[2*k] = a33[k];
                    mop_b[2*k] = b33[k];
                end
            end
            v3alu_pkg::OP_CROSS: begin
                mop_a[0] = a33[1]; mop_b[0] = b33[2];
                mop_a[1] = a33[2]; mop_b[1] = b33[1];
                mop_a[2] = a33[2]; mop_b[2] = b33[0];
                mop_a[3] = a33[0]; mop_b[3] = b33[2];
                mop_a[4] = a33[0]; mop_b[4] = b33[1];
                mop_a[5] = a33[1]; mop_b[5] = b33[0];
            end
            v3alu_pkg::OP_LEN, v3alu_pkg::OP_NORM: begin
                for (int k = 0; k < 3; k++) begin
                    mop_a[2*k] = a33[k];
                    mop_b[2*k] = a33[k];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int m = 0; m < v3alu_pkg::NUM_MULS; m++) begin
            r_prod[m] <= mop_a[m] * mop_b[m];
        end
    end

    // squares are non-negative, their sum stays below 2^64
    assign sum_sq = r_prod[0][63:0] + r_prod[2][63:0] + r_prod[4][63:0];

    v3alu_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_load (sq_load),
        .i_step (sq_step),
        .i_rad  (v3alu_pkg::RAD_W'({sum_sq, {v3alu_pkg::FRAC_BITS{1'b0}}})),
        .o_root (root)
    );

    always_comb begin
        if (r_item.op == v3alu_pkg::OP_NORM) begin
            divisor = root;
        end else begin
            divisor = v3alu_pkg::DIVS_W'(v3alu_pkg::mag(r_item.s));
        end
        for (int k = 0; k < NL; k++) begin
            dividend[k] = {v3alu_pkg::mag(r_item.a[k]), {v3alu_pkg::FRAC_BITS{1'b0}}};
            n_neg[k]    = r_item.a[k][DW-1] ^
                          ((r_item.op == v3alu_pkg::OP_DIV) && r_item.s[DW-1]);
        end
    end

    for (genvar g = 0; g < NL; g++) begin : g_div
        v3alu_div_lane u_lane (
            .i_clk      (i_clk),
            .i_load     (dv_load),
            .i_step     (dv_step),
            .i_dividend (dividend[g]),
            .i_divisor  (divisor),
            .o_quot     (quot[g])
        );
    end

    // sequencer
    assign out_free = !r_m_valid || i_m_tready;
    assign sq_step  = (r_state == ST_SQRT) && (r_cnt != '0);
    assign dv_step  = (r_state == ST_DIV) && (r_cnt != '0);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_pop   = 1'b0;
        sq_load = 1'b0;
        dv_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_pop   = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                case (r_item.op)
                    v3alu_pkg::OP_DIV: begin
                        if (r_item.s == '0) begin
                            n_state = ST_FIN;
                        end else begin
                            dv_load = 1'b1;
                            n_cnt   = v3alu_pkg::CNT_W'(v3alu_pkg::DVD_W);
                            n_state = ST_DIV;
                        end
                    end
                    v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB, v3alu_pkg::OP_NOP: begin
                        n_state = ST_FIN;
                    end
                    default: begin
                        n_state = ST_SUM;
                    end
                endcase
            end
            ST_SUM: begin
                if (r_item.op == v3alu_pkg::OP_LEN || r_item.op == v3alu_pkg::OP_NORM) begin
                    sq_load = 1'b1;
                    n_cnt   = v3alu_pkg::CNT_W'(v3alu_pkg::ROOT_W);
                    n_state = ST_SQRT;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_SQRT: begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - v3alu_pkg::CNT_W'(1);
                end else if (r_item.op == v3alu_pkg::OP_NORM && root != '0) begin
                    dv_load = 1'b1;
                    n_cnt   = v3alu_pkg::CNT_W'(v3alu_pkg::DVD_W);
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - v3alu_pkg::CNT_W'(1);
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result select
    always_comb begin
        dz     = (r_item.op == v3alu_pkg::OP_DIV) && (r_item.s == '0);
        scal_v = '0;
        for (int k = 0; k < NL; k++) begin
            lane_v[k] = '0;
            case (r_item.op)
                v3alu_pkg::OP_ADD: begin
                    lane_v[k] = WW'($signed(r_item.a[k])) + WW'($signed(r_item.b[k]));
                end
                v3alu_pkg::OP_SUB: begin
                    lane_v[k] = WW'($signed(r_item.a[k])) - WW'($signed(r_item.b[k]));
                end
                v3alu_pkg::OP_SCALE, v3alu_pkg::OP_LERP: begin
                    lane_v[k] = (WW'(r_prod[2*k]) + WW'(r_prod[2*k+1]))
                                >>> v3alu_pkg::FRAC_BITS;
                end
                v3alu_pkg::OP_CROSS: begin
                    if (k < 3) begin
                        lane_v[k] = (WW'(r_prod[2*k]) - WW'(r_prod[2*k+1]))
                                    >>> v3alu_pkg::FRAC_BITS;
                    end
                end
                v3alu_pkg::OP_DIV, v3alu_pkg::OP_NORM: begin
                    if (dz) begin
                        if (r_item.a[k][DW-1]) begin
                            lane_v[k] = v3alu_pkg::SAT_MIN;
                        end else if (r_item.a[k] != '0) begin
                            lane_v[k] = v3alu_pkg::SAT_MAX;
                        end
                    end else if (r_item.op == v3alu_pkg::OP_DIV || (k < 3 && root != '0)) begin
                        lane_v[k] = r_neg[k] ? -WW'(quot[k]) : WW'(quot[k]);
                    end
                end
                default: begin
                end
            endcase
            lane_s[k] = v3alu_pkg::sat_val(lane_v[k]);
        end
        if (r_item.op == v3alu_pkg::OP_DOT) begin
            scal_v = (WW'(r_prod[0]) + WW'(r_prod[2]) + WW'(r_prod[4]))
                     >>> v3alu_pkg::FRAC_BITS;
        end else if (r_item.op == v3alu_pkg::OP_LEN) begin
            scal_v = WW'(root);
        end
        scal_s  = v3alu_pkg::sat_val(scal_v);
        any_ovf = scal_s.ovf;
        for (int k = 0; k < NL; k++) begin
            any_ovf = any_ovf | lane_s[k].ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (dv_load) begin
            r_neg <= n_neg;
        end
        if (r_state == ST_FIN && out_free) begin
            r_m_data <= {scal_s.val, lane_s[3].val, lane_s[2].val,
                         lane_s[1].val, lane_s[0].val};
            if (dz) begin
                r_m_user <= v3alu_pkg::STAT_DZ;
            end else if (any_ovf) begin
                r_m_user <= v3alu_pkg::STAT_OVF;
            end else begin
                r_m_user <= v3alu_pkg::STAT_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == ST_FIN && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && out_free) |=> (o_m_tvalid && r_state == ST_IDLE))
        else $error("finished item did not reach the output register");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt != '0) |=> (r_state == ST_DIV))
        else $error("divide left before all quotient bits");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_IDLE && i_item_valid))
        else $error("queue popped outside idle");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= v3alu_pkg::CNT_W'(v3alu_pkg::DVD_W))
        else $error("step counter out of range");

endmodule

// ===== design/vec3_homogeneous_alu_unit.sv =====
// top level of the vec3 homogeneous alu
// usage:
//   input beats arrive on i_s_tvalid/o_s_tready; i_s_tdata carries a xyzw, b xyzw
//   and the scalar (32-bit signed Q16.16 each), i_s_tuser the 4-bit opcode
//   results leave on o_m_tvalid/i_m_tready; o_m_tdata carries r xyzw and
//   scalar_out, o_m_tuser the status (ok, divide by zero, overflow)
//   the front end queues up to four items, so the sender keeps going while
//   the execution engine works or the receiver stalls
//   the engine takes one item at a time; its states from queue head to output:
//     add, sub, undefined codes, divide by zero: idle, mul, fin
//     scale, lerp, dot, cross: idle, mul, sum, fin
//     divide: idle, mul, div (one quotient bit per cycle, 48 bits), fin
//     length: idle, mul, sum, a 40-step root, fin; normalize: the same with a 48-step divide
//     after the root, except for a zero-length vector, which skips the divide
//   input beats are registered in the queue before they reach the queue head
//   a stalled receiver holds the result in the output register; the engine
//   waits with its next result until that register is taken
//   synchronous active-low reset empties the queue and clears valid
module vec3_homogeneous_alu_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in
    input  logic [v3alu_pkg::IN_DATA_W-1:0] i_s_tdata,
    // operation
    input  logic [v3alu_pkg::OP_W-1:0]      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // r_x, r_y, r_z, r_w, scalar_out
    output logic [v3alu_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // status
    output logic [v3alu_pkg::STATUS_W-1:0]  o_m_tuser
);

    v3alu_pkg::t_item item;
    logic item_valid, pop;

    v3alu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_pop        (pop)
    );

    v3alu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_pop        (pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

endmodule

// ===== bench/vec3_alu_checker.sv =====
// checker for the vec3 alu: watches both streams, predicts each result and compares
module vec3_alu_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [v3alu_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic [v3alu_pkg::OP_W-1:0]        i_s_tuser,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [v3alu_pkg::OUT_DATA_W-1:0]  i_m_tdata,
    input  logic [v3alu_pkg::STATUS_W-1:0]    i_m_tuser,
    output int                                o_errors,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = v3alu_pkg::FRAC_BITS;
    localparam int DW = v3alu_pkg::DATA_W;

    typedef struct {
        logic [DW-1:0]                  r [4];
        logic [DW-1:0]                  sc;
        logic [v3alu_pkg::STATUS_W-1:0] st;
    } t_alu_result;

    t_alu_result result_q[$];
    string       lane_name [4] = '{"r_x", "r_y", "r_z", "r_w"};

    // floor of v / 2^FB on a wide signed value
    function automatic logic signed [127:0] fx_floor(input logic signed [127:0] v);
        return v >>> FB;
    endfunction

    function automatic logic [DW-1:0] clip32(input logic signed [127:0] v,
                                             inout logic ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // integer floor square root on a wide unsigned value, for roots below 2^48
    function automatic logic [63:0] isqrt(input logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = 0;
        for (int bit_i = 47; bit_i >= 0; bit_i--) begin
            c = r | (64'd1 << bit_i);
            sq = c * c;
            if (sq <= x) r = c;
        end
        return r;
    endfunction

    function automatic t_alu_result predict_alu(
            input logic [v3alu_pkg::IN_DATA_W-1:0] d,
            input logic [v3alu_pkg::OP_W-1:0] op);
        logic signed [127:0] a [4];
        logic signed [127:0] b [4];
        logic signed [127:0] v [4];
        logic signed [127:0] s, t, sc, one;
        logic [127:0]        sq;
        logic                ovf, dz;
        t_alu_result         res;
        one = 128'sd1 <<< FB;
        for (int i = 0; i < 4; i++) begin
            a[i] = $signed(d[i*DW +: DW]);
            b[i] = $signed(d[(4+i)*DW +: DW]);
            v[i] = 0;
        end
        s = $signed(d[8*DW +: DW]);
        sc = 0;
        ovf = 1'b0;
        dz = 1'b0;
        case (op)
            v3alu_pkg::OP_ADD: for (int i = 0; i < 4; i++) v[i] = a[i] + b[i];
            v3alu_pkg::OP_SUB: for (int i = 0; i < 4; i++) v[i] = a[i] - b[i];
            v3alu_pkg::OP_SCALE: for (int i = 0; i < 4; i++) v[i] = fx_floor(a[i] * s);
            v3alu_pkg::OP_DIV: begin
                if (s == 0) begin
                    dz = 1'b1;
                    for (int i = 0; i < 4; i++)
                        v[i] = a[i] > 0 ? 128'sd2147483647 :
                               (a[i] < 0 ? -128'sd2147483648 : 128'sd0);
                end else begin
                    for (int i = 0; i < 4; i++) v[i] = (a[i] * one) / s;
                end
            end
            v3alu_pkg::OP_LERP: begin
                t = s < 0 ? 128'sd0 : (s > one ? one : s);
                for (int i = 0; i < 4; i++)
                    v[i] = fx_floor(a[i] * (one - t) + b[i] * t);
            end
            v3alu_pkg::OP_DOT: sc = fx_floor(a[0]*b[0] + a[1]*b[1] + a[2]*b[2]);
            v3alu_pkg::OP_CROSS: begin
                v[0] = fx_floor(a[1]*b[2] - a[2]*b[1]);
                v[1] = fx_floor(a[2]*b[0] - a[0]*b[2]);
                v[2] = fx_floor(a[0]*b[1] - a[1]*b[0]);
            end
            v3alu_pkg::OP_LEN, v3alu_pkg::OP_NORM: begin
                // sum of squares is cut to 64 bits like the datapath
                sq = 128'((a[0]*a[0] + a[1]*a[1] + a[2]*a[2]) & {64{1'b1}});
                t = $signed({64'd0, isqrt(sq << FB)});
                if (op == v3alu_pkg::OP_LEN) sc = t;
                else if (t != 0)
                    for (int i = 0; i < 3; i++) v[i] = (a[i] * one) / t;
            end
            default: ;
        endcase
        for (int i = 0; i < 4; i++) res.r[i] = clip32(v[i], ovf);
        res.sc = clip32(sc, ovf);
        res.st = dz ? v3alu_pkg::STAT_DZ : (ovf ? v3alu_pkg::STAT_OVF : v3alu_pkg::STAT_OK);
        return res;
    endfunction

    assign o_pending = result_q.size();

    always @(posedge i_clk) begin
        t_alu_result want;
        int          bad;
        bad = 0;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                result_q.push_back(predict_alu(i_s_tdata, i_s_tuser));
            if (i_m_tvalid && i_m_tready) begin
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    bad++;
                end else begin
                    want = result_q.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (i_m_tdata[i*DW +: DW] !== want.r[i]) begin
                            $error("%s: expected %h, got %h", lane_name[i], want.r[i],
                                   i_m_tdata[i*DW +: DW]);
                            bad++;
                        end
                    if (i_m_tdata[4*DW +: DW] !== want.sc) begin
                        $error("scalar_out: expected %h, got %h", want.sc,
                               i_m_tdata[4*DW +: DW]);
                        bad++;
                    end
                    if (i_m_tuser !== want.st) begin
                        $error("status: expected %0d, got %0d", want.st, i_m_tuser);
                        bad++;
                    end
                end
            end
            o_errors <= o_errors + bad;
        end
    end

endmodule

// ===== bench/testbench.sv =====
// top of the vec3 alu bench: clock, reset, stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPW = v3alu_pkg::OP_W;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [v3alu_pkg::IN_DATA_W-1:0]   s_tdata = '0;
    logic [OPW-1:0]                    s_tuser = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [v3alu_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic [v3alu_pkg::STATUS_W-1:0]    m_tuser;
    int                                errors;
    int                                pending;
    bit                                stall_free = 1'b0;

    always #10 i_clk = ~i_clk;

    vec3_homogeneous_alu_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    vec3_alu_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'h00010000;
            4: return 32'hffff0000;
            5, 6: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_scalar(input logic [OPW-1:0] op);
        int k;
        k = $urandom_range(0, 9);
        if (op == v3alu_pkg::OP_DIV && k == 0) return 32'h0;
        if (op == v3alu_pkg::OP_LERP && k < 6) return $urandom_range(0, 32'h10000);
        return pick_word();
    endfunction

    // one input beat; waits for acceptance, valid stays up when the next beat follows
    task automatic send_beat(input logic [OPW-1:0] op,
                             input logic [31:0] w [9]);
        int g;
        g = stall_free ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        for (int i = 0; i < 9; i++) s_tdata[i*32 +: 32] <= w[i];
        s_tuser <= op;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // receiver: random stalls, with stall-free stretches
    initial begin
        int g;
        @(posedge i_clk iff i_rst_n);
        forever begin
            g = stall_free ? 0 : gap_len();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        logic [31:0]    w [9];
        logic [OPW-1:0] op;
        int             waited;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: codes 0 to 11 and nop with extremes, zero divisor, lerp clamps, zero length
        for (int k = 0; k < 24; k++) begin
            op = OPW'(k % 12);
            for (int i = 0; i < 9; i++)
                w[i] = (k < 12) ? ((k % 2) ? 32'h7fffffff : 32'h80000000) : pick_word();
            if (k == 3 || k == 15) w[8] = 32'h0;
            if (k == 4) w[8] = 32'hffff0000;
            if (k == 16) w[8] = 32'h00030000;
            if (k == 20) begin
                w[0] = 0; w[1] = 0; w[2] = 0;
            end
            if (k == 23) op = v3alu_pkg::OP_NOP;
            send_beat(op, w);
        end

        for (int n = 0; n < 1350; n++) begin
            stall_free = ((n / 150) % 3) == 2;
            op = ($urandom_range(0, 19) == 0) ? OPW'($urandom_range(9, 15))
                                              : OPW'($urandom_range(0, 8));
            for (int i = 0; i < 9; i++) w[i] = pick_word();
            w[8] = pick_scalar(op);
            if (op == v3alu_pkg::OP_NORM && $urandom_range(0, 19) == 0) begin
                w[0] = 0; w[1] = 0; w[2] = 0;
            end
            send_beat(op, w);
        end
        s_tvalid <= 1'b0;

        stall_free = 1'b1;
        waited = 0;
        while (pending != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #40ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
design/v3alu_pkg.sv
design/v3alu_front.sv
design/v3alu_sqrt.sv
design/v3alu_div_lane.sv
design/v3alu_back.sv
design/vec3_homogeneous_alu_unit.sv
bench/vec3_alu_checker.sv
bench/testbench.sv
